@@ rtl/nsp_pkg.sv @@
// shared types and constants for the nested section profiler
// no dependencies; every other file but nsp_ram refers to it by scoped names
package nsp_pkg;

   localparam int STACK_DEPTH = 32;
   localparam int STK_AW      = 5;
   localparam int SP_W        = 6;
   localparam int SLOT_W      = 5;
   localparam int TS_W        = 64;
   localparam int CNT_W       = 32;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_UNDERFLOW = 2'd2,
      ST_BAD_SLOT  = 2'd3
   } status_type;

   // per-slot statistics, one memory word
   typedef struct packed {
      logic [TS_W-1:0]  min_elapsed;
      logic [TS_W-1:0]  max_elapsed;
      logic [TS_W-1:0]  total_elapsed;
      logic [CNT_W-1:0] close_count;
   } stats_type;

   localparam int STATS_W = $bits(stats_type);

   localparam stats_type STATS_RESET = '{
      min_elapsed:   '1,
      max_elapsed:   '0,
      total_elapsed: '0,
      close_count:   '0
   };

   // decoded item handed from the front stage to the update stage
   typedef struct packed {
      logic              pop;
      status_type        status;
      logic [SLOT_W-1:0] slot;
      logic [TS_W-1:0]   timestamp;
      logic [SP_W-1:0]   depth;
   } item_type;

   typedef struct packed {
      status_type        status;
      logic [SLOT_W-1:0] closed_slot;
      logic [TS_W-1:0]   elapsed;
      logic [TS_W-1:0]   min_elapsed;
      logic [TS_W-1:0]   max_elapsed;
      logic [TS_W-1:0]   total_elapsed;
      logic [CNT_W-1:0]  close_count;
      logic [SP_W-1:0]   nesting_depth;
   } rsp_word_type;

endpackage

@@ rtl/nsp_ifs.sv @@
// valid/ready channel interfaces for profiler requests and responses
// depends on nsp_pkg for field widths
interface nsp_req_if;
   logic                      valid;
   logic                      ready;
   logic                      op;
   logic [nsp_pkg::SLOT_W-1:0] slot;
   logic [nsp_pkg::TS_W-1:0]   timestamp;

   modport source (output valid, op, slot, timestamp, input ready);
   modport sink   (input valid, op, slot, timestamp, output ready);
endinterface

interface nsp_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [1:0]                  status;
   logic [nsp_pkg::SLOT_W-1:0]  closed_slot;
   logic [nsp_pkg::TS_W-1:0]    elapsed;
   logic [nsp_pkg::TS_W-1:0]    min_elapsed;
   logic [nsp_pkg::TS_W-1:0]    max_elapsed;
   logic [nsp_pkg::TS_W-1:0]    total_elapsed;
   logic [nsp_pkg::CNT_W-1:0]   close_count;
   logic [nsp_pkg::SP_W-1:0]    nesting_depth;

   modport source (output valid, status, closed_slot, elapsed, min_elapsed, max_elapsed,
                   total_elapsed, close_count, nesting_depth, input ready);
   modport sink   (input valid, status, closed_slot, elapsed, min_elapsed, max_elapsed,
                   total_elapsed, close_count, nesting_depth, output ready);
endinterface

@@ rtl/nsp_ram.sv @@
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
module nsp_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 32,
   parameter int AW    = 5
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/nsp_front.sv @@
// front stage: classifies push/pop, owns the open-section stack and pointer,
// issues slot memory reads and start-time writes; uses nsp_pkg
module nsp_front #(
   parameter int SLOTS = 32,
   parameter int AW    = 5
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  logic                        op,
   input  logic [nsp_pkg::SLOT_W-1:0]  slot,
   input  logic [nsp_pkg::TS_W-1:0]    timestamp,
   output logic [AW-1:0]               rd_addr,
   output logic                        start_wr_en,
   output logic [AW-1:0]               start_wr_addr,
   output nsp_pkg::item_type           item
);

   localparam logic [8:0] SLOT_LIM = 9'(SLOTS);

   logic [nsp_pkg::SLOT_W-1:0] stack_ff [nsp_pkg::STACK_DEPTH];
   logic [nsp_pkg::SP_W-1:0]   sp_ff, sp_in;
   nsp_pkg::item_type          item_ff, item_in;
   logic [nsp_pkg::SP_W-1:0]   sp_m1;
   logic [nsp_pkg::SLOT_W-1:0] tos;
   logic                       push_ok, pop_ok;

   assign sp_m1 = sp_ff - nsp_pkg::SP_W'(1);
   assign tos   = stack_ff[sp_m1[nsp_pkg::STK_AW-1:0]];

   always_comb begin
      push_ok           = 1'b0;
      pop_ok            = 1'b0;
      item_in.pop       = op;
      item_in.timestamp = timestamp;
      item_in.slot      = slot;
      item_in.status    = nsp_pkg::ST_OK;
      if (!op) begin
         if (9'(slot) >= SLOT_LIM) begin
            item_in.status = nsp_pkg::ST_BAD_SLOT;
         end else if (sp_ff >= nsp_pkg::SP_W'(nsp_pkg::STACK_DEPTH)) begin
            item_in.status = nsp_pkg::ST_OVERFLOW;
         end else begin
            push_ok = 1'b1;
         end
      end else begin
         if (sp_ff == '0 || sp_ff > nsp_pkg::SP_W'(nsp_pkg::STACK_DEPTH)) begin
            item_in.status = nsp_pkg::ST_UNDERFLOW;
            item_in.slot   = '0;
         end else if (9'(tos) >= SLOT_LIM) begin
            item_in.status = nsp_pkg::ST_BAD_SLOT;
            item_in.slot   = tos;
         end else begin
            item_in.slot = tos;
            pop_ok       = 1'b1;
         end
      end
      sp_in = sp_ff;
      if (accept && push_ok) begin
         sp_in = sp_ff + nsp_pkg::SP_W'(1);
      end else if (accept && pop_ok) begin
         sp_in = sp_m1;
      end
      item_in.depth = sp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff <= '0;
      end else begin
         sp_ff <= sp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
      if (accept && push_ok) begin
         stack_ff[sp_ff[nsp_pkg::STK_AW-1:0]] <= slot;
      end
   end

   assign rd_addr       = AW'(op ? tos : slot);
   assign start_wr_en   = accept && push_ok;
   assign start_wr_addr = AW'(slot);
   assign item          = item_ff;

endmodule

@@ rtl/nsp_update.sv @@
// update stage: elapsed time, min/max/total/count update, slot valid bits
// and response formatting; uses nsp_pkg
module nsp_update #(
   parameter int SLOTS = 32,
   parameter int AW    = 5
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       accept,
   input  logic                       stage_valid,
   input  logic [AW-1:0]              rd_addr,
   input  nsp_pkg::item_type          item,
   input  logic [nsp_pkg::TS_W-1:0]   start_time,
   input  nsp_pkg::stats_type         stats_rd,
   output logic                       stats_wr_en,
   output logic [AW-1:0]              stats_wr_addr,
   output nsp_pkg::stats_type         stats_wr,
   output nsp_pkg::rsp_word_type      rsp_word
);

   logic [SLOTS-1:0]          vld_ff, vld_in;
   logic                      rd_vld_ff;
   logic [AW-1:0]             addr_ff;
   nsp_pkg::stats_type        cur, upd;
   logic [nsp_pkg::TS_W-1:0]  el;
   logic                      ok;

   // unwritten slot reads as its reset statistics
   assign cur = rd_vld_ff ? stats_rd : nsp_pkg::STATS_RESET;
   assign el  = item.timestamp - start_time;
   assign ok  = (item.status == nsp_pkg::ST_OK);

   always_comb begin
      upd.min_elapsed   = (el < cur.min_elapsed) ? el : cur.min_elapsed;
      upd.max_elapsed   = (el > cur.max_elapsed) ? el : cur.max_elapsed;
      upd.total_elapsed = cur.total_elapsed + el;
      upd.close_count   = cur.close_count + nsp_pkg::CNT_W'(1);
   end

   assign stats_wr_en   = stage_valid && item.pop && ok;
   assign stats_wr_addr = addr_ff;
   assign stats_wr      = upd;

   always_comb begin
      vld_in = vld_ff;
      if (stats_wr_en) begin
         vld_in[addr_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_vld_ff <= vld_ff[rd_addr];
         addr_ff   <= rd_addr;
      end
   end

   always_comb begin
      rsp_word.status        = item.status;
      rsp_word.closed_slot   = item.slot;
      rsp_word.nesting_depth = item.depth;
      rsp_word.elapsed       = '0;
      rsp_word.min_elapsed   = '0;
      rsp_word.max_elapsed   = '0;
      rsp_word.total_elapsed = '0;
      rsp_word.close_count   = '0;
      if (ok && item.pop) begin
         rsp_word.elapsed       = el;
         rsp_word.min_elapsed   = upd.min_elapsed;
         rsp_word.max_elapsed   = upd.max_elapsed;
         rsp_word.total_elapsed = upd.total_elapsed;
         rsp_word.close_count   = upd.close_count;
      end else if (ok) begin
         rsp_word.min_elapsed   = cur.min_elapsed;
         rsp_word.max_elapsed   = cur.max_elapsed;
         rsp_word.total_elapsed = cur.total_elapsed;
         rsp_word.close_count   = cur.close_count;
      end
   end

endmodule

@@ rtl/nested_section_profiler.sv @@
// top level of the nested section profiler: front stage, slot memories,
// update stage and response register; uses nsp_pkg, nsp_ifs, nsp_ram, nsp_front and nsp_update
//
// Each request word is a push (open a section on a slot) or a pop (close the
// innermost open section) with a 64-bit timestamp; every request yields exactly
// one response word carrying status, the slot, the elapsed cycles and that
// slot's min, max, wrapping total and wrapping close count, plus the nesting
// depth afterwards. Up to 32 sections nest. For each item the stack is first
// consulted and the slot memories are read; then the statistics memory is
// written back and the response register loaded. No new request is taken
// while an item is in this write-back step, because of the read-modify-
// write of the statistics memory. The response register holds one word; a
// request is taken only while it is empty or being read out in that same
// cycle, so a response waiting on rsp_ch.ready holds req_ch.ready low.
// Errors (bad slot, overflow, underflow) leave all state untouched and report
// zero statistics. Statistics of slots never closed read as their reset value
// (min all ones) through per-slot valid bits; there is no clearing pass.
module nested_section_profiler #(
   parameter int SLOTS = 32
) (
   input  logic       clock,
   input  logic       reset,
   nsp_req_if.sink    req_ch,
   nsp_rsp_if.source  rsp_ch
);

   localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   // handshake and stage control
   logic                      accept;
   logic                      stage_ff, stage_in;
   logic                      out_vld_ff, out_vld_in;
   nsp_pkg::rsp_word_type     rsp_ff;

   // between stages
   logic [AW-1:0]             rd_addr;
   logic                      start_wr_en;
   logic [AW-1:0]             start_wr_addr;
   nsp_pkg::item_type         item;
   logic [nsp_pkg::TS_W-1:0]  start_time;
   logic [nsp_pkg::STATS_W-1:0] stats_rd_bits;
   logic                      stats_wr_en;
   logic [AW-1:0]             stats_wr_addr;
   nsp_pkg::stats_type        stats_wr;
   nsp_pkg::rsp_word_type     rsp_word;

   // one item in flight; response slot must be free or draining
   assign req_ch.ready = !stage_ff && (!out_vld_ff || rsp_ch.ready);
   assign accept       = req_ch.valid && req_ch.ready;

   assign stage_in = accept;

   always_comb begin
      out_vld_in = out_vld_ff;
      if (stage_ff) begin
         out_vld_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff   <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         stage_ff   <= stage_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // response payload register
   always_ff @(posedge clock) begin
      if (stage_ff) begin
         rsp_ff <= rsp_word;
      end
   end

   // stack, pointer and request decode
   nsp_front #(
      .SLOTS (SLOTS),
      .AW    (AW)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .op            (req_ch.op),
      .slot          (req_ch.slot),
      .timestamp     (req_ch.timestamp),
      .rd_addr       (rd_addr),
      .start_wr_en   (start_wr_en),
      .start_wr_addr (start_wr_addr),
      .item          (item)
   );

   // start time of the last open per slot
   nsp_ram #(
      .WIDTH (nsp_pkg::TS_W),
      .DEPTH (SLOTS),
      .AW    (AW)
   ) u_start_ram (
      .clock   (clock),
      .wr_en   (start_wr_en),
      .wr_addr (start_wr_addr),
      .wr_data (req_ch.timestamp),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (start_time)
   );

   // per-slot min, max, total and count
   nsp_ram #(
      .WIDTH (nsp_pkg::STATS_W),
      .DEPTH (SLOTS),
      .AW    (AW)
   ) u_stats_ram (
      .clock   (clock),
      .wr_en   (stats_wr_en),
      .wr_addr (stats_wr_addr),
      .wr_data (stats_wr),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (stats_rd_bits)
   );

   // elapsed time and statistics update
   nsp_update #(
      .SLOTS (SLOTS),
      .AW    (AW)
   ) u_update (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .stage_valid   (stage_ff),
      .rd_addr       (rd_addr),
      .item          (item),
      .start_time    (start_time),
      .stats_rd      (nsp_pkg::stats_type'(stats_rd_bits)),
      .stats_wr_en   (stats_wr_en),
      .stats_wr_addr (stats_wr_addr),
      .stats_wr      (stats_wr),
      .rsp_word      (rsp_word)
   );

   // response channel
   assign rsp_ch.valid         = out_vld_ff;
   assign rsp_ch.status        = rsp_ff.status;
   assign rsp_ch.closed_slot   = rsp_ff.closed_slot;
   assign rsp_ch.elapsed       = rsp_ff.elapsed;
   assign rsp_ch.min_elapsed   = rsp_ff.min_elapsed;
   assign rsp_ch.max_elapsed   = rsp_ff.max_elapsed;
   assign rsp_ch.total_elapsed = rsp_ff.total_elapsed;
   assign rsp_ch.close_count   = rsp_ff.close_count;
   assign rsp_ch.nesting_depth = rsp_ff.nesting_depth;

endmodule

@@ bench/nested_section_profiler_test.sv @@
// self-checking bench for the nested section profiler: drives push and pop
// words, predicts every response word and compares them field by field
// depends on rtl/nsp_pkg.sv, rtl/nsp_ifs.sv and rtl/nested_section_profiler.sv
module nested_section_profiler_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS          = 32;
   localparam logic OP_PUSH      = 1'b0;
   localparam logic OP_POP       = 1'b1;
   // a long receiver hold-off plus random gaps stays far below this
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_CYCLES    = 150;
   // room for the last item and the response register, with margin
   localparam int TAIL_CYCLES    = 20;

   logic clock;
   logic reset;

   nsp_req_if req_ch ();
   nsp_rsp_if rsp_ch ();

   nested_section_profiler #(
      .SLOTS(SLOTS)
   ) u_dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   // ------------------------------------------------------------------
   // profiler state as the bench sees it
   // ------------------------------------------------------------------
   logic [nsp_pkg::SLOT_W-1:0] stack_slots [nsp_pkg::STACK_DEPTH];
   logic [nsp_pkg::SP_W-1:0]   open_depth;
   logic [nsp_pkg::TS_W-1:0]   start_ts    [SLOTS];
   nsp_pkg::stats_type         slot_stats  [SLOTS];

   nsp_pkg::rsp_word_type pending_words[$];   // response words still owed by the block
   int           mismatches;
   int           req_idle_pct;       // chance in percent of a sender gap per cycle
   int           rsp_idle_pct;       // chance in percent of a receiver stall per cycle
   logic         rsp_hold;           // long receiver hold-off in progress
   logic [nsp_pkg::TS_W-1:0] ts_now; // timestamp source for the sender, moved by next_stamp
   int           idle_cycles;
   event         hold_go;

   // work out the response word of one accepted request word and update state
   function automatic nsp_pkg::rsp_word_type predict_word(
         input logic op,
         input logic [nsp_pkg::SLOT_W-1:0] slot,
         input logic [nsp_pkg::TS_W-1:0] stamp);
      nsp_pkg::rsp_word_type      w;
      logic [nsp_pkg::SLOT_W-1:0] s;
      logic [nsp_pkg::TS_W-1:0]   el;
      w = '0;
      w.status = nsp_pkg::ST_OK;
      if (op == OP_PUSH) begin
         w.closed_slot = slot;
         // range check comes before the overflow check
         if (int'(slot) >= SLOTS) begin
            w.status = nsp_pkg::ST_BAD_SLOT;
         end else if (int'(open_depth) >= nsp_pkg::STACK_DEPTH) begin
            w.status = nsp_pkg::ST_OVERFLOW;
         end else begin
            // a second push on an open slot moves its start time
            start_ts[slot] = stamp;
            stack_slots[open_depth[nsp_pkg::STK_AW-1:0]] = slot;
            open_depth = open_depth + nsp_pkg::SP_W'(1);
            w.min_elapsed   = slot_stats[slot].min_elapsed;
            w.max_elapsed   = slot_stats[slot].max_elapsed;
            w.total_elapsed = slot_stats[slot].total_elapsed;
            w.close_count   = slot_stats[slot].close_count;
         end
      end else if (open_depth == '0) begin
         // underflow reports slot zero and empty statistics
         w.status = nsp_pkg::ST_UNDERFLOW;
      end else begin
         open_depth = open_depth - nsp_pkg::SP_W'(1);
         s  = stack_slots[open_depth[nsp_pkg::STK_AW-1:0]];
         el = stamp - start_ts[s];      // wraps modulo 2^64
         if (el < slot_stats[s].min_elapsed) slot_stats[s].min_elapsed = el;
         if (el > slot_stats[s].max_elapsed) slot_stats[s].max_elapsed = el;
         slot_stats[s].total_elapsed = slot_stats[s].total_elapsed + el;
         slot_stats[s].close_count   = slot_stats[s].close_count + nsp_pkg::CNT_W'(1);
         w.closed_slot   = s;
         w.elapsed       = el;
         w.min_elapsed   = slot_stats[s].min_elapsed;
         w.max_elapsed   = slot_stats[s].max_elapsed;
         w.total_elapsed = slot_stats[s].total_elapsed;
         w.close_count   = slot_stats[s].close_count;
      end
      w.nesting_depth = open_depth;
      return w;
   endfunction

   function automatic void note_failure(input string text);
      mismatches++;
      if (mismatches <= 10) $display("%0t ns: %s", $realtime, text);
   endfunction

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (want !== got)
         note_failure($sformatf("%s mismatch: expected %h, got %h", name, want, got));
   endfunction

   // ------------------------------------------------------------------
   // clock, receiver, hold-off and watchdog
   // ------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // take response words, compare with the oldest prediction, then pick the
   // next ready value
   always @(posedge clock) begin : rsp_side
      nsp_pkg::rsp_word_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (pending_words.size() == 0) begin
            note_failure("response word with no request outstanding");
         end else begin
            want = pending_words.pop_front();
            check_field("status",        64'(want.status),      64'(rsp_ch.status));
            check_field("closed_slot",   64'(want.closed_slot), 64'(rsp_ch.closed_slot));
            check_field("elapsed",       want.elapsed,          rsp_ch.elapsed);
            check_field("min_elapsed",   want.min_elapsed,      rsp_ch.min_elapsed);
            check_field("max_elapsed",   want.max_elapsed,      rsp_ch.max_elapsed);
            check_field("total_elapsed", want.total_elapsed,    rsp_ch.total_elapsed);
            check_field("close_count",   64'(want.close_count), 64'(rsp_ch.close_count));
            check_field("nesting_depth", 64'(want.nesting_depth),
                        64'(rsp_ch.nesting_depth));
         end
      end
      rsp_ch.ready <= !rsp_hold && ($urandom_range(99) >= rsp_idle_pct);
   end

   // long receiver hold-off, counted here so the sender keeps offering words
   initial begin
      rsp_hold = 1'b0;
      forever begin
         @(hold_go);
         rsp_hold <= 1'b1;
         repeat (HOLD_CYCLES) @(posedge clock);
         rsp_hold <= 1'b0;
      end
   end

   // end the run if neither side moves a word for too long
   always @(posedge clock) begin
      if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
          (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[nested_section_profiler] ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // sender side
   // ------------------------------------------------------------------

   // offer one request word, with random gaps ahead of it, and record the
   // prediction once it is taken
   task automatic send_word(input logic op, input logic [nsp_pkg::SLOT_W-1:0] slot,
                            input logic [nsp_pkg::TS_W-1:0] stamp);
      while ($urandom_range(99) < req_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.op        <= op;
      req_ch.slot      <= slot;
      req_ch.timestamp <= stamp;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      pending_words.push_back(predict_word(op, slot, stamp));
   endtask

   task automatic go_quiet();
      req_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   // sender pauses until every owed response word has come back
   task automatic wait_drained();
      go_quiet();
      while (pending_words.size() != 0) @(posedge clock);
   endtask

   // mostly a counter that moves forward, sometimes a jump anywhere or a
   // small step back so that elapsed wraps
   function automatic logic [nsp_pkg::TS_W-1:0] next_stamp();
      int pick;
      pick = $urandom_range(99);
      if (pick < 85)      ts_now = ts_now + 64'($urandom_range(500, 1));
      else if (pick < 95) ts_now = {$urandom, $urandom};
      else                ts_now = ts_now - 64'($urandom_range(300, 1));
      return ts_now;
   endfunction

   // a few hot slots so statistics pile up, the rest spread over all slots
   function automatic logic [nsp_pkg::SLOT_W-1:0] pick_slot();
      if ($urandom_range(99) < 60) return nsp_pkg::SLOT_W'($urandom_range(3));
      return nsp_pkg::SLOT_W'($urandom_range(SLOTS - 1));
   endfunction

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // field extremes, wrapping elapsed and total, re-opened slot, empty pop
   task automatic test_directed();
      send_word(OP_POP,  5'd0,  64'd0);                   // pop on an empty stack
      send_word(OP_PUSH, 5'd0,  64'd0);                   // never-closed slot stats
      send_word(OP_PUSH, 5'd31, '1);
      send_word(OP_POP,  5'd0,  64'd0);                   // elapsed wraps to one
      send_word(OP_POP,  5'd21, '1);                      // slot field ignored on pop
      send_word(OP_PUSH, 5'd5,  64'd100);
      send_word(OP_PUSH, 5'd5,  64'd200);                 // same slot opened again
      send_word(OP_POP,  5'd0,  64'd250);
      send_word(OP_POP,  5'd0,  64'd300);                 // measured from the later start
      send_word(OP_PUSH, 5'd9,  64'h1234);
      send_word(OP_POP,  5'd0,  64'h1234);                // zero-length section
      send_word(OP_PUSH, 5'd7,  64'd0);
      send_word(OP_POP,  5'd0,  64'hC000_0000_0000_0000);
      send_word(OP_PUSH, 5'd7,  64'd0);
      send_word(OP_POP,  5'd0,  64'hC000_0000_0000_0000); // total wraps
      send_word(OP_PUSH, 5'd10, 64'h5555_5555_5555_5555);
      send_word(OP_POP,  5'd0,  64'hAAAA_AAAA_AAAA_AAAA);
   endtask

   // fill the stack to the top, push once more, then empty it and pop once more
   task automatic test_overflow();
      for (int i = 0; i < nsp_pkg::STACK_DEPTH; i++)
         send_word(OP_PUSH, nsp_pkg::SLOT_W'(i), next_stamp());
      send_word(OP_PUSH, 5'd3, next_stamp());
      for (int i = 0; i < nsp_pkg::STACK_DEPTH; i++)
         send_word(OP_POP, pick_slot(), next_stamp());
      send_word(OP_POP, 5'd17, next_stamp());
   endtask

   // receiver holds off while words keep coming, so the block backs up
   task automatic test_backpressure();
      wait_drained();
      -> hold_go;
      for (int i = 0; i < 24; i++)
         send_word((open_depth == '0 || i % 3 == 0) ? OP_PUSH : OP_POP,
                   pick_slot(), next_stamp());
      wait_drained();
   endtask

   // well-formed nesting with random content, some stray pops and overflows
   task automatic test_random(input int count);
      int   push_pct;
      logic op;
      push_pct = 50;
      for (int n = 0; n < count; n++) begin
         if (n % 40 == 0) begin
            case ($urandom_range(2))
               0: begin push_pct = 30; end
               1: begin push_pct = 50; end
               default: begin push_pct = 75; end   // climbs to a full stack
            endcase
         end
         if (n % 120 == 119) wait_drained();
         if ($urandom_range(99) < 8) begin
            op = 1'($urandom_range(1));
         end else if (open_depth == '0) begin
            op = ($urandom_range(99) < 95) ? OP_PUSH : OP_POP;
         end else if (int'(open_depth) >= nsp_pkg::STACK_DEPTH) begin
            op = ($urandom_range(99) < 85) ? OP_POP : OP_PUSH;
         end else begin
            op = ($urandom_range(99) < push_pct) ? OP_PUSH : OP_POP;
         end
         send_word(op, pick_slot(), next_stamp());
      end
   endtask

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------
   initial begin
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.op        = OP_PUSH;
      req_ch.slot      = '0;
      req_ch.timestamp = '0;
      rsp_ch.ready     = 1'b0;
      idle_cycles      = 0;
      mismatches       = 0;
      ts_now           = '0;
      req_idle_pct     = 30;
      rsp_idle_pct     = 30;
      open_depth       = '0;
      foreach (stack_slots[i]) stack_slots[i] = '0;
      foreach (start_ts[i]) start_ts[i] = '0;
      foreach (slot_stats[i]) slot_stats[i] = nsp_pkg::STATS_RESET;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_overflow();
      test_backpressure();

      // long stretch with neither side idling
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      test_random(150);
      req_idle_pct = 30;
      rsp_idle_pct = 30;
      test_random(500);

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_words.size() == 0) begin
         $display("[nested_section_profiler] OK");
      end else begin
         $display("[nested_section_profiler] ERROR");
      end
      $finish;
   end

endmodule
